>>> rtl/core/lptd_pkg.sv
// Shared types and constants for the length-prefixed transform deframer.
// Used by the parser, the result queue and the top level; no dependencies.
package lptd_pkg;

  localparam logic [7:0] BIN_TAG      = 8'h10;
  localparam int         REC_LEN      = 19;
  localparam int         HDR_LEN      = 8;
  localparam int         PREFIX_LEN   = 4;
  localparam int         QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    KIND_RECORD     = 3'd0,
    KIND_FRAME_DONE = 3'd1,
    KIND_BAD_HEADER = 3'd2,
    KIND_SIZE_ERR   = 3'd3,
    KIND_OTHER      = 3'd4,
    KIND_FATAL      = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    PH_PREFIX  = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_RECORDS = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_HALTED  = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] entity_id;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic [31:0] pos_z_bits;
    logic [15:0] heading_code;
    logic [7:0]  motion_mode;
    logic [31:0] frame_tick;
    logic [15:0] record_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    logic       halted;
  } parse_status_t;

endpackage

>>> rtl/core/length_prefixed_transform_deframer.sv
// Top level of the length-prefixed transform deframer: input register, parser,
// result queue and the codec register port. Depends on lptd_pkg, lptd_parser
// and lptd_result_queue.
//
//   Channel  Handshake                  Payload
//   input    in_valid / in_ready        rx_byte
//   output   out_valid / out_ready      kind .. record_count, last
//   config   psel/penable/pwrite/pready paddr, pwdata, prdata (codec_id at 0)
//
// One stream byte can be taken in every cycle while the queue has room for two
// results. A byte waits in the input register while the parser decodes it, and
// its results enter a four-entry result queue when the parser consumes the byte.
// The input register holds its byte while more than two results are waiting, and
// the input stalls until the output side drains the queue.
// Reset clears the framing state and the queue; record bytes need no reset.
module length_prefixed_transform_deframer #(
  parameter int MAX_PAYLOAD_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] entity_id,
  output logic [31:0] pos_x_bits,
  output logic [31:0] pos_y_bits,
  output logic [31:0] pos_z_bits,
  output logic [15:0] heading_code,
  output logic [7:0]  motion_mode,
  output logic [31:0] frame_tick,
  output logic [15:0] record_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lptd_pkg::*;

  logic          byte_valid;
  logic [7:0]    byte_q;
  logic          consume;
  logic          room2;
  logic [7:0]    codec_id;
  result_t       res0, res1, head;
  parse_status_t status;
  logic          pop;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == 1'b0) ? {24'h0, codec_id} : 32'h0;
  assign consume = byte_valid && room2;
  assign in_ready = !byte_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      codec_id <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (consume) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  lptd_parser #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .rx_byte (byte_q),
    .codec_id(codec_id),
    .res0    (res0),
    .res1    (res1),
    .status  (status)
  );

  assign pop = out_valid && out_ready;

  lptd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (status.count),
    .d0        (res0),
    .d1        (res1),
    .pop       (pop),
    .head      (head),
    .head_valid(out_valid),
    .room2     (room2)
  );

  assign kind         = head.kind;
  assign entity_id    = head.entity_id;
  assign pos_x_bits   = head.pos_x_bits;
  assign pos_y_bits   = head.pos_y_bits;
  assign pos_z_bits   = head.pos_z_bits;
  assign heading_code = head.heading_code;
  assign motion_mode  = head.motion_mode;
  assign frame_tick   = head.frame_tick;
  assign record_count = head.record_count;
  assign last         = head.last;

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FRAME_DONE |-> last)
    else $error("frame done result not marked last");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    status.halted |=> status.halted)
    else $error("parser left the halted state without reset");

  a_nonrecord_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_RECORD |-> entity_id == '0 && motion_mode == '0)
    else $error("record fields set on a non-record result");

  a_no_results_halted: assert property (@(posedge clk) disable iff (rst)
    status.halted |-> status.count == 2'd0)
    else $error("result produced while halted");

endmodule

>>> rtl/core/lptd_parser.sv
// Frame parser: holds the framing state and, while consume is high, decodes one
// stream byte per cycle into up to two results. Depends on lptd_pkg.
module lptd_parser #(
  parameter int MAX_PAYLOAD_BYTES = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   consume,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             codec_id,
  output lptd_pkg::result_t      res0,
  output lptd_pkg::result_t      res1,
  output lptd_pkg::parse_status_t status
);
  import lptd_pkg::*;

  localparam int IdxW = $clog2(MAX_PAYLOAD_BYTES + 1);

  phase_t            phase, phase_next;
  logic [31:0]       frame_length, frame_length_next;
  logic [IdxW-1:0]   payload_index, payload_index_next;
  logic [31:0]       header_tick, header_tick_next;
  logic [15:0]       header_count, header_count_next;
  logic [4:0]        record_offset, record_offset_next;
  logic [7:0]        record_bytes [REC_LEN];

  logic [IdxW-1:0]   idx_inc;
  logic              frame_end;
  logic [31:0]       len_shift;
  logic [15:0]       count_full;
  logic [20:0]       count_x19;
  logic [31:0]       need_len;
  logic [1:0]        n;

  assign idx_inc    = payload_index + IdxW'(1);
  assign frame_end  = 32'(idx_inc) >= frame_length;
  assign len_shift  = {frame_length[23:0], rx_byte};
  assign count_full = {rx_byte, header_count[7:0]};
  assign count_x19  = {1'b0, count_full, 4'b0} + {4'b0, count_full, 1'b0} + {5'b0, count_full};
  assign need_len   = 32'(count_x19) + 32'(HDR_LEN);

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    payload_index_next = payload_index;
    header_tick_next   = header_tick;
    header_count_next  = header_count;
    record_offset_next = record_offset;
    res0 = '0;
    res1 = '0;
    n    = 2'd0;
    if (consume) begin
      case (phase)
        PH_PREFIX: begin
          frame_length_next  = len_shift;
          record_offset_next = record_offset + 5'd1;
          if (record_offset == 5'(PREFIX_LEN - 1)) begin
            record_offset_next = '0;
            payload_index_next = '0;
            if (len_shift > 32'(MAX_PAYLOAD_BYTES)) begin
              phase_next = PH_HALTED;
              res0.kind  = KIND_FATAL;
              n          = 2'd1;
            end else if (len_shift == '0) begin
              res0.kind = KIND_OTHER;
              n         = 2'd1;
            end else begin
              phase_next = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          if (payload_index == IdxW'(0)) begin
            header_tick_next = '0;
            if (rx_byte != codec_id) begin
              res0.kind  = KIND_OTHER;
              n          = 2'd1;
              phase_next = PH_SKIP;
            end else if (frame_length < 32'(HDR_LEN)) begin
              res0.kind  = KIND_BAD_HEADER;
              n          = 2'd1;
              phase_next = PH_SKIP;
            end
          end else if (payload_index == IdxW'(1)) begin
            if (rx_byte != BIN_TAG) begin
              res0.kind  = KIND_BAD_HEADER;
              n          = 2'd1;
              phase_next = PH_SKIP;
            end
          end else if (payload_index == IdxW'(2)) begin
            header_tick_next[7:0] = rx_byte;
          end else if (payload_index == IdxW'(3)) begin
            header_tick_next[15:8] = rx_byte;
          end else if (payload_index == IdxW'(4)) begin
            header_tick_next[23:16] = rx_byte;
          end else if (payload_index == IdxW'(5)) begin
            header_tick_next[31:24] = rx_byte;
          end else if (payload_index == IdxW'(6)) begin
            header_count_next = {8'h00, rx_byte};
          end else begin
            header_count_next = count_full;
            if (frame_length != need_len) begin
              res0.kind  = KIND_SIZE_ERR;
              n          = 2'd1;
              phase_next = PH_SKIP;
            end else if (count_full == '0) begin
              res0.kind       = KIND_FRAME_DONE;
              res0.frame_tick = header_tick;
              n               = 2'd1;
            end else begin
              phase_next         = PH_RECORDS;
              record_offset_next = '0;
            end
          end
        end
        PH_RECORDS: begin
          record_offset_next = record_offset + 5'd1;
          if (record_offset == 5'(REC_LEN - 1)) begin
            record_offset_next = '0;
            res0.kind         = KIND_RECORD;
            res0.entity_id    = {record_bytes[3], record_bytes[2],
                                 record_bytes[1], record_bytes[0]};
            res0.pos_x_bits   = {record_bytes[7], record_bytes[6],
                                 record_bytes[5], record_bytes[4]};
            res0.pos_y_bits   = {record_bytes[11], record_bytes[10],
                                 record_bytes[9], record_bytes[8]};
            res0.pos_z_bits   = {record_bytes[15], record_bytes[14],
                                 record_bytes[13], record_bytes[12]};
            res0.heading_code = {record_bytes[17], record_bytes[16]};
            res0.motion_mode  = rx_byte;
            n                 = 2'd1;
            if (frame_end) begin
              res1.kind         = KIND_FRAME_DONE;
              res1.frame_tick   = header_tick;
              res1.record_count = header_count;
              n                 = 2'd2;
            end
          end
        end
        default: begin
        end
      endcase
      if (phase != PH_PREFIX && phase != PH_HALTED) begin
        payload_index_next = idx_inc;
        if (frame_end) begin
          phase_next         = PH_PREFIX;
          payload_index_next = '0;
          frame_length_next  = '0;
          record_offset_next = '0;
        end
      end
    end
    res0.last = (n == 2'd1);
    res1.last = (n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PREFIX;
      frame_length  <= '0;
      payload_index <= '0;
      header_tick   <= '0;
      header_count  <= '0;
      record_offset <= '0;
    end else begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      payload_index <= payload_index_next;
      header_tick   <= header_tick_next;
      header_count  <= header_count_next;
      record_offset <= record_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && phase == PH_RECORDS && record_offset < 5'(REC_LEN)) begin
      record_bytes[record_offset] <= rx_byte;
    end
  end

  assign status.count  = n;
  assign status.halted = (phase == PH_HALTED);

endmodule

>>> rtl/core/lptd_result_queue.sv
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on lptd_pkg.
module lptd_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  lptd_pkg::result_t d0,
  input  lptd_pkg::result_t d1,
  input  logic              pop,
  output lptd_pkg::result_t head,
  output logic              head_valid,
  output logic              room2
);
  import lptd_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  result_t          mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count, count_next;
  logic [PtrW-1:0]  wr_ptr1;

  assign wr_ptr1    = wr_ptr + PtrW'(1);
  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign room2      = (count <= CntW'(QUEUE_DEPTH - 2));
  assign count_next = count + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= d1;
    end
  end

endmodule
